/* rtl/u8u16_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants for the utf-8 to utf-16 stream decoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  localparam int DefMaxStringBytes = 128;

  localparam int ByteW  = 8;
  localparam int UnitW  = 16;
  localparam int CountW = 8;
  localparam int BytesW = 9;

  localparam logic [BytesW-1:0] BytesMax = '1;

  typedef enum logic [1:0] {
    PH_LEAD     = 2'd0,
    PH_TWO_LAST = 2'd1,
    PH_THREE_MID = 2'd2,
    PH_THREE_LAST = 2'd3
  } phase_t;

  typedef struct packed {
    logic              valid;
    logic [UnitW-1:0]  code_unit;
    logic              is_end;
    logic [BytesW-1:0] byte_count;
  } result_t;

endpackage

/* rtl/u8u16_decode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16_decode
// Sequence state and combinational decode of one byte into an optional result.
// ----------------------------------------------------------------------------
module u8u16_decode
  import u8u16_pkg::*;
#(
  parameter int MAX_STRING_BYTES = DefMaxStringBytes
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [ByteW-1:0] data_byte,
  output result_t          result
);

  localparam logic [CountW-1:0] MaxCount = CountW'(MAX_STRING_BYTES);

  phase_t            phase, phase_next;
  logic [4:0]        lead_bits, lead_bits_next;
  logic [5:0]        middle_bits, middle_bits_next;
  logic [UnitW-1:0]  previous_unit, previous_unit_next;
  logic [CountW-1:0] unit_count, unit_count_next;

  logic              is_zero;
  logic [BytesW:0]   bytes_raw;

  assign is_zero   = (data_byte == '0);
  assign bytes_raw = {1'b0, unit_count, 1'b0} + (BytesW+1)'(2);

  // result of the current byte
  always_comb begin
    result = '0;
    if (is_zero) begin
      result.valid      = 1'b1;
      result.is_end     = 1'b1;
      result.byte_count = bytes_raw[BytesW] ? BytesMax : bytes_raw[BytesW-1:0];
    end else begin
      unique case (phase)
        PH_LEAD: begin
          if (!data_byte[7]) begin
            result.valid     = 1'b1;
            result.code_unit = UnitW'(data_byte);
          end else if (data_byte[7:5] != 3'b110 && data_byte[7:4] != 4'b1110) begin
            result.valid     = 1'b1;
            result.code_unit = previous_unit;
          end
        end
        PH_TWO_LAST: begin
          result.valid     = 1'b1;
          result.code_unit = UnitW'({lead_bits, data_byte[5:0]});
        end
        PH_THREE_MID: begin
          result.valid = 1'b0;
        end
        PH_THREE_LAST: begin
          result.valid     = 1'b1;
          result.code_unit = {lead_bits[3:0], middle_bits, data_byte[5:0]};
        end
        default: begin
          result.valid = 1'b0;
        end
      endcase
    end
  end

  // next state
  always_comb begin
    phase_next         = phase;
    lead_bits_next     = lead_bits;
    middle_bits_next   = middle_bits;
    previous_unit_next = previous_unit;
    unit_count_next    = unit_count;
    if (is_zero) begin
      phase_next         = PH_LEAD;
      lead_bits_next     = '0;
      middle_bits_next   = '0;
      previous_unit_next = '0;
      unit_count_next    = '0;
    end else begin
      unique case (phase)
        PH_LEAD: begin
          if (data_byte[7:5] == 3'b110) begin
            lead_bits_next = data_byte[4:0];
            phase_next     = PH_TWO_LAST;
          end else if (data_byte[7:4] == 4'b1110) begin
            lead_bits_next = data_byte[4:0];
            phase_next     = PH_THREE_MID;
          end
        end
        PH_THREE_MID: begin
          middle_bits_next = data_byte[5:0];
          phase_next       = PH_THREE_LAST;
        end
        default: begin
          phase_next = PH_LEAD;
        end
      endcase
      if (result.valid) begin
        previous_unit_next = result.code_unit;
        phase_next         = PH_LEAD;
        if (unit_count < MaxCount) begin
          unit_count_next = unit_count + CountW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_LEAD;
      lead_bits     <= '0;
      middle_bits   <= '0;
      previous_unit <= '0;
      unit_count    <= '0;
    end else if (step) begin
      phase         <= phase_next;
      lead_bits     <= lead_bits_next;
      middle_bits   <= middle_bits_next;
      previous_unit <= previous_unit_next;
      unit_count    <= unit_count_next;
    end
  end

endmodule

/* rtl/u8u16_out_reg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16_out_reg
// Result register; refills in the same cycle its request is taken.
// ----------------------------------------------------------------------------
module u8u16_out_reg
  import u8u16_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  result_t           result,
  output logic              ready,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [31:0]       m_tdata,  // code_unit[15:0], byte_count[24:16], zero pad
  output logic              m_tlast   // is_end
);

  logic [UnitW-1:0]  code_unit;
  logic [BytesW-1:0] byte_count;
  logic              is_end;
  logic              load;

  assign ready = !m_tvalid || m_tready;
  assign load  = step && result.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      code_unit  <= result.code_unit;
      byte_count <= result.byte_count;
      is_end     <= result.is_end;
    end
  end

  assign m_tdata = {7'd0, byte_count, code_unit};
  assign m_tlast = is_end;

endmodule

/* rtl/utf8_to_utf16_stream_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_utf16_stream_decoder
// Decodes a zero-terminated utf-8 byte stream into utf-16 code units.
// output: each result is registered and appears on the master side the cycle after its byte
// throughput: one byte per cycle while the result register can drain, set by the single decode stage
// the input is ready while the result register is empty or drains in the same cycle
// reset: synchronous; clears sequence state, counts and the valid flag of the result register
// ----------------------------------------------------------------------------
module utf8_to_utf16_stream_decoder
  import u8u16_pkg::*;
#(
  parameter int MAX_STRING_BYTES = DefMaxStringBytes
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte[7:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // code_unit[15:0], byte_count[24:16]
  output logic        m_tlast    // is_end
);

  result_t result;
  logic    step;

  assign step = s_tvalid && s_tready;

  u8u16_decode #(
    .MAX_STRING_BYTES(MAX_STRING_BYTES)
  ) u_decode (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .data_byte (s_tdata),
    .result    (result)
  );

  u8u16_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .result   (result),
    .ready    (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

/* tb/utf8_to_utf16_stream_decoder_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_utf16_stream_decoder_tb
// Streams zero-terminated utf-8 strings into the decoder with bursty input and
// a stalling output, predicts every utf-16 code unit and end item in the
// bench, and compares each output request field by field in arrival order.
// Covers 1-, 2- and 3-byte sequences, invalid leads, truncated sequences,
// unchecked continuation bits and the unit count bound.
// ----------------------------------------------------------------------------
module utf8_to_utf16_stream_decoder_tb;
  import u8u16_pkg::*;

  localparam int MaxUnits   = DefMaxStringBytes;
  localparam int IdleLimit  = 2000;
  localparam int ByteTarget = 675;

  typedef struct packed {
    logic [UnitW-1:0]  code_unit;
    logic              is_end;
    logic [BytesW-1:0] byte_count;
  } utf16_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // data_byte[7:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // code_unit[15:0], byte_count[24:16]
  logic        m_tlast;        // is_end

  logic [7:0]  utf8_bytes[$];
  utf16_item_t expected_units[$];
  int          mismatch_count = 0;
  int          idle_cycles = 0;

  // decoder shadow state
  phase_t            dec_phase = PH_LEAD;
  logic [4:0]        dec_lead = '0;
  logic [5:0]        dec_mid = '0;
  logic [UnitW-1:0]  dec_prev = '0;
  logic [CountW-1:0] dec_units = '0;

  // sender and receiver pacing
  int burst_left = 0;
  int gap_left = 0;
  int stall_window = 0;
  int stall_pct = 0;

  utf8_to_utf16_stream_decoder #(
    .MAX_STRING_BYTES(MaxUnits)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic decode_utf8_byte(input logic [7:0] b);
    utf16_item_t      item;
    logic [UnitW-1:0] unit;
    bit               emit;
    int               bytes;
    emit = 1'b0;
    unit = '0;
    if (b == 8'h00) begin
      bytes = int'(dec_units) * 2 + 2;
      if (bytes > int'(BytesMax)) bytes = int'(BytesMax);
      item.code_unit  = '0;
      item.is_end     = 1'b1;
      item.byte_count = bytes[BytesW-1:0];
      expected_units.push_back(item);
      dec_phase = PH_LEAD;
      dec_lead  = '0;
      dec_mid   = '0;
      dec_prev  = '0;
      dec_units = '0;
    end else begin
      case (dec_phase)
        PH_LEAD: begin
          if (b <= 8'h7f) begin
            unit = {8'h00, b};
            emit = 1'b1;
          end else if ((b & 8'he0) == 8'hc0) begin
            dec_lead  = b[4:0];
            dec_phase = PH_TWO_LAST;
          end else if ((b & 8'hf0) == 8'he0) begin
            dec_lead  = b[4:0];
            dec_phase = PH_THREE_MID;
          end else begin
            unit = dec_prev;
            emit = 1'b1;
          end
        end
        PH_TWO_LAST: begin
          unit = {5'b0, dec_lead, b[5:0]};
          emit = 1'b1;
        end
        PH_THREE_MID: begin
          dec_mid   = b[5:0];
          dec_phase = PH_THREE_LAST;
        end
        default: begin
          unit = {dec_lead[3:0], dec_mid, b[5:0]};
          emit = 1'b1;
        end
      endcase
      if (emit) begin
        dec_prev = unit;
        if (int'(dec_units) < MaxUnits) dec_units = dec_units + CountW'(1);
        dec_phase = PH_LEAD;
        item.code_unit  = unit;
        item.is_end     = 1'b0;
        item.byte_count = '0;
        expected_units.push_back(item);
      end
    end
  endtask

  // continuation byte: mostly 10xxxxxx, sometimes any nonzero value
  function automatic logic [7:0] cont_byte();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(1, 255));
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  task automatic add_char(input int kind);
    case (kind)
      0: utf8_bytes.push_back(8'($urandom_range(1, 127)));
      1: begin
        utf8_bytes.push_back(8'hc0 | 8'($urandom_range(0, 31)));
        utf8_bytes.push_back(cont_byte());
      end
      default: begin
        utf8_bytes.push_back(8'he0 | 8'($urandom_range(0, 15)));
        utf8_bytes.push_back(cont_byte());
        utf8_bytes.push_back(cont_byte());
      end
    endcase
  endtask

  initial begin
    int nchar;
    int kind;
    // empty string, invalid leads repeating the previous unit
    utf8_bytes = '{8'h00,
                   8'h80, 8'h41, 8'hff, 8'h00,
                   8'h7f, 8'hc0, 8'h80, 8'hdf, 8'hbf, 8'h00,
                   8'he0, 8'h80, 8'h80, 8'hef, 8'hbf, 8'hbf, 8'h00,
                   8'hc3, 8'hff, 8'h00,
                   8'hc2, 8'h00,
                   8'he2, 8'h82, 8'h00};
    // one string long enough to hit the unit count bound
    repeat (MaxUnits + 2) add_char(0);
    utf8_bytes.push_back(8'h00);
    while (utf8_bytes.size() < ByteTarget) begin
      if ($urandom_range(0, 99) < 4) begin
        nchar = $urandom_range(MaxUnits + 1, MaxUnits + 12);
        repeat (nchar) add_char($urandom_range(0, 2));
      end else begin
        nchar = $urandom_range(0, 12);
        repeat (nchar) begin
          if ($urandom_range(0, 9) == 0) utf8_bytes.push_back(8'($urandom_range(1, 255)));
          else add_char($urandom_range(0, 2));
        end
        // sequence cut short by the terminator
        if ($urandom_range(0, 11) == 0) begin
          kind = $urandom_range(0, 2);
          if (kind == 0) begin
            utf8_bytes.push_back(8'hc0 | 8'($urandom_range(0, 31)));
          end else begin
            utf8_bytes.push_back(8'he0 | 8'($urandom_range(0, 15)));
            if (kind == 2) utf8_bytes.push_back(cont_byte());
          end
        end
      end
      utf8_bytes.push_back(8'h00);
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    while (utf8_bytes.size() != 0 || s_tvalid || expected_units.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("utf8_to_utf16_stream_decoder_tb: clean");
    end else begin
      $display("utf8_to_utf16_stream_decoder_tb: errors");
    end
    $finish;
  end

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid   <= 1'b0;
      s_tdata    <= '0;
      burst_left = $urandom_range(1, 40);
      gap_left   = 0;
    end else begin
      if (s_tvalid && s_tready) decode_utf8_byte(s_tdata);
      if (!(s_tvalid && !s_tready)) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (utf8_bytes.size() != 0) begin
          s_tvalid <= 1'b1;
          s_tdata  <= utf8_bytes.pop_front();
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    utf16_item_t got;
    utf16_item_t want;
    if (rst) begin
      m_tready     <= 1'b0;
      stall_window = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.code_unit  = m_tdata[15:0];
        got.byte_count = m_tdata[24:16];
        got.is_end     = m_tlast;
        if (expected_units.size() == 0) begin
          $display("%0t: unexpected request code_unit=%h is_end=%b byte_count=%0d",
                   $time, got.code_unit, got.is_end, got.byte_count);
          mismatch_count++;
        end else begin
          want = expected_units.pop_front();
          if (got.code_unit !== want.code_unit) begin
            $display("%0t: code_unit expected %h actual %h", $time, want.code_unit,
                     got.code_unit);
            mismatch_count++;
          end
          if (got.is_end !== want.is_end) begin
            $display("%0t: is_end expected %b actual %b", $time, want.is_end, got.is_end);
            mismatch_count++;
          end
          if (got.byte_count !== want.byte_count) begin
            $display("%0t: byte_count expected %0d actual %0d", $time, want.byte_count,
                     got.byte_count);
            mismatch_count++;
          end
        end
      end
      if (stall_window <= 0) begin
        stall_window = $urandom_range(8, 64);
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      stall_window--;
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("utf8_to_utf16_stream_decoder_tb: errors");
        $finish;
      end
    end
  end

endmodule

/* utf8_to_utf16_stream_decoder.f */
rtl/u8u16_pkg.sv
rtl/u8u16_decode.sv
rtl/u8u16_out_reg.sv
rtl/utf8_to_utf16_stream_decoder.sv
tb/utf8_to_utf16_stream_decoder_tb.sv
